// ===== rtl/single_float_alu_truncating_macros.svh =====
// Assertion macros for the truncating float ALU
`ifndef SINGLE_FLOAT_ALU_TRUNCATING_MACROS_SVH
`define SINGLE_FLOAT_ALU_TRUNCATING_MACROS_SVH

// Implication checked on every edge outside reset
`define SFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define SFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfa_pkg
// Opcodes, constants and stage payload types for the truncating float ALU.
// ----------------------------------------------------------------------------
package sfa_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_NEG   = 3'd2,
    OP_ITOF  = 3'd3,
    OP_FTOI  = 3'd4
  } opcode_t;

  localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [22:0] FRAC_MASK = 23'h7F_FFFF;
  localparam int          EXP_BIAS  = 127;

  // Leading-zero count of a 32-bit word (32 when zero).
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Stage 1 -> 2: aligned significands, or a finished result word.
  typedef struct packed {
    logic        done;       // result already known
    logic [31:0] word;       // result when done
    logic [2:0]  kind;       // opcode class
    logic        sub;        // effective subtract
    logic        sa;
    logic        sb;
    logic [23:0] fa;
    logic [23:0] fb;
    logic [7:0]  e;
    logic [31:0] ival;       // int magnitude / ftoi operand
    logic        isign;
  } s1_t;

  // Stage 2 -> 3: raw magnitude and leading zero count.
  typedef struct packed {
    logic        done;
    logic [31:0] word;
    logic [2:0]  kind;
    logic        sign;
    logic [31:0] mag;
    logic [5:0]  lz;
    logic [9:0]  e;
  } s2_t;

endpackage

// ===== rtl/sfa_align.sv =====
// ----------------------------------------------------------------------------
// sfa_align
// Stage 1: decode, zero-operand bypass, exponent compare and right shift.
// ----------------------------------------------------------------------------
module sfa_align (
  input  logic [2:0]       opcode,
  input  logic [31:0]      operand_a,
  input  logic [31:0]      operand_b,
  output sfa_pkg::s1_t     s1
);
  import sfa_pkg::*;

  logic [31:0] b_eff;
  logic [7:0]  ea, eb, d;
  logic [23:0] fa, fb;
  logic        a_ge;

  always_comb begin
    b_eff = (opcode == OP_SUB) ? (operand_b ^ SIGN_MASK) : operand_b;
    ea    = operand_a[30:23];
    eb    = b_eff[30:23];
    fa    = {1'b1, operand_a[22:0]};
    fb    = {1'b1, b_eff[22:0]};
    a_ge  = (ea >= eb);
    d     = a_ge ? (ea - eb) : (eb - ea);

    s1       = '0;
    s1.kind  = opcode;
    s1.sa    = operand_a[31];
    s1.sb    = b_eff[31];
    s1.sub   = operand_a[31] ^ b_eff[31];
    s1.e     = a_ge ? ea : eb;
    s1.fa    = fa;
    s1.fb    = fb;
    if (a_ge) s1.fb = (d < 8'd24) ? (fb >> d) : '0;
    else      s1.fa = (d < 8'd24) ? (fa >> d) : '0;
    s1.isign = operand_a[31];
    s1.ival  = operand_a;

    unique case (opcode)
      OP_ADD, OP_SUB: begin
        if (b_eff[30:0] == '0) begin
          s1.done = 1'b1;
          s1.word = operand_a;
        end else if (operand_a[30:0] == '0) begin
          s1.done = 1'b1;
          s1.word = b_eff;
        end
      end
      OP_NEG: begin
        s1.done = 1'b1;
        s1.word = operand_a ^ SIGN_MASK;
      end
      OP_ITOF: begin
        s1.ival = operand_a[31] ? (32'd0 - operand_a) : operand_a;
        if (operand_a == '0) s1.done = 1'b1;
      end
      OP_FTOI: ;
      default: s1.done = 1'b1;
    endcase
  end

endmodule

// ===== rtl/sfa_addsub.sv =====
// ----------------------------------------------------------------------------
// sfa_addsub
// Stage 2: significand add/subtract, leading-zero count, ftoi shift.
// ----------------------------------------------------------------------------
module sfa_addsub (
  input  sfa_pkg::s1_t s1,
  output sfa_pkg::s2_t s2
);
  import sfa_pkg::*;

  logic [24:0] sum;
  logic [9:0]  ue;   // unbiased exponent for ftoi, signed
  logic [31:0] r;

  always_comb begin
    s2      = '0;
    s2.done = s1.done;
    s2.word = s1.word;
    s2.kind = s1.kind;
    s2.e    = {2'b00, s1.e};
    sum     = '0;
    ue      = 10'({2'b00, s1.ival[30:23]}) - 10'(EXP_BIAS);
    r       = {8'd0, 1'b1, s1.ival[22:0]};

    if (s1.kind == OP_ADD || s1.kind == OP_SUB) begin
      if (!s1.sub) begin
        sum     = {1'b0, s1.fa} + {1'b0, s1.fb};
        s2.sign = s1.sa;
      end else if (s1.fa >= s1.fb) begin
        sum     = {1'b0, s1.fa - s1.fb};
        s2.sign = s1.sa;
      end else begin
        sum     = {1'b0, s1.fb - s1.fa};
        s2.sign = s1.sb;
      end
      if (sum == '0 && !s1.done) begin
        s2.done = 1'b1;
        s2.word = '0;
      end
      s2.mag = {7'd0, sum};
      s2.lz  = lzc32({7'd0, sum});
    end else if (s1.kind == OP_ITOF) begin
      s2.sign = s1.isign;
      s2.mag  = s1.ival;
      s2.lz   = lzc32(s1.ival);
    end else if (s1.kind == OP_FTOI && !s1.done) begin
      if (ue[9]) begin
        r = '0;
      end else if (ue >= 10'd23) begin
        r = ((ue - 10'd23) < 10'd32) ? (r << (ue - 10'd23)) : '0;
      end else begin
        r = r >> (10'd23 - ue);
      end
      s2.done = 1'b1;
      s2.word = s1.isign ? (32'd0 - r) : r;
    end
  end

endmodule

// ===== rtl/sfa_norm.sv =====
// ----------------------------------------------------------------------------
// sfa_norm
// Stage 3: normalize shift, exponent adjust, underflow/overflow, pack.
// ----------------------------------------------------------------------------
module sfa_norm (
  input  sfa_pkg::s2_t s2,
  output logic [31:0]  word
);
  import sfa_pkg::*;

  logic [31:0] m;
  logic [9:0]  e;

  always_comb begin
    m    = s2.mag << s2.lz;
    e    = '0;
    word = s2.word;
    if (!s2.done) begin
      if (s2.kind == OP_ITOF) begin
        e    = 10'(31 + EXP_BIAS) - {4'd0, s2.lz};
        word = {s2.sign, e[7:0], m[30:8]};
      end else begin
        // sum sits in bits 24:0; bit 24 set means lz == 7
        e = s2.e + 10'd8 - {4'd0, s2.lz};
        if (s2.e + 10'd8 <= {4'd0, s2.lz}) word = '0;
        else if (e > 10'd255)               word = {s2.sign, EXP_MASK[30:0]};
        else                                word = {s2.sign, e[7:0], m[30:8]};
      end
    end
  end

endmodule

// ===== rtl/single_float_alu_truncating.sv =====
// ----------------------------------------------------------------------------
// single_float_alu_truncating
// Truncating single-precision add/sub/negate/convert unit, three stages.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | opcode, operand_a, operand_b
//  out     | out_valid | out_stall | result_word
//
// One request per cycle unless out stalls a full pipe; stages are align, add/count, normalize.
// Rate is set by the pipeline registers, one stage each.
// Reset clears the stage valid bits only.
// A stall on out holds each full stage with only full stages after it; empty stages still fill.
`include "single_float_alu_truncating_macros.svh"
module single_float_alu_truncating (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_word
);
  import sfa_pkg::*;

  s1_t         s1_d, s1;
  s2_t         s2_d, s2;
  logic [31:0] w_d;
  logic        v1, v2, v3;
  logic        en1, en2, en3;

  sfa_align  u_align (.opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
                      .s1(s1_d));
  sfa_addsub u_addsub (.s1(s1), .s2(s2_d));
  sfa_norm   u_norm (.s2(s2), .word(w_d));

  assign en3 = !v3 || !out_stall;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall  = !en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
    if (en1) s1 <= s1_d;
    if (en2) s2 <= s2_d;
    if (en3) result_word <= w_d;
  end

  `SFA_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(result_word),
    "result changed under stall")
  `SFA_ASSERT_IMP(a_stall_full, in_stall, v1 && v2 && v3 && out_stall,
    "input stalled with room in the pipe")
  `SFA_ASSERT_NEXT(a_flow, v2 && !out_stall, v3, "stage 2 request lost")

endmodule
